>>> rtl/hcc_pkg.sv
`timescale 1ns / 1ps

package hcc_pkg;

	localparam int MAX_VERTICES_DEF = 16;

	localparam int MODE_W  = 2;
	localparam int VERT_W  = 4;
	localparam int VCNT_W  = 5;
	localparam int COUNT_W = 41;

	localparam logic [VCNT_W-1:0] VCNT_RESET = 5'd16;

	localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_COUNT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	// search engine status toward the top level
	typedef struct packed {
		logic busy;
		logic done;
	} hcc_stat_t;

endpackage

>>> rtl/hcc_search.sv
`timescale 1ns / 1ps

// Backtracking walker: one candidate test, push or pop per cycle.
module hcc_search #(
	parameter int MAX_VERTICES = hcc_pkg::MAX_VERTICES_DEF,
	localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
	localparam int DW = $clog2(MAX_VERTICES + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [DW-1:0]                n_vert,
	output logic [VW-1:0]                row_addr,
	input  logic [MAX_VERTICES-1:0]      row,
	input  logic                         take,
	output hcc_pkg::hcc_stat_t           stat,
	output logic [hcc_pkg::COUNT_W-1:0]  count
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DONE
	} state_t;

	state_t                       state_q;
	logic [DW-1:0]                n_q;
	logic [DW-1:0]                depth_q;
	logic [DW-1:0]                cand_q;
	logic [VW-1:0]                top_q;
	logic [MAX_VERTICES-1:0]      used_q;
	logic [hcc_pkg::COUNT_W-1:0]  count_q;
	logic [VW-1:0]                stack_q [MAX_VERTICES];

	logic [VW-1:0] cand_idx;
	logic [DW-1:0] dm2;
	logic [VW-1:0] pop_top;
	logic          at_full;
	logic          cand_end;
	logic          push;

	assign cand_idx = cand_q[VW-1:0];
	assign dm2      = depth_q - DW'(2);
	assign pop_top  = stack_q[dm2[VW-1:0]];
	assign at_full  = (depth_q == n_q);
	assign cand_end = (cand_q == n_q);
	assign push     = (state_q == S_RUN) && !at_full && !cand_end &&
	                  !used_q[cand_idx] && row[cand_idx];

	assign row_addr  = top_q;
	assign count     = count_q;
	assign stat.busy = (state_q != S_IDLE);
	assign stat.done = (state_q == S_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
			depth_q <= '0;
			cand_q  <= '0;
			top_q   <= '0;
			used_q  <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_RUN;
						n_q     <= n_vert;
						depth_q <= DW'(1);
						cand_q  <= DW'(1);
						top_q   <= '0;
						used_q  <= MAX_VERTICES'(1);
						count_q <= '0;
					end
				end
				S_RUN: begin
					if (at_full || cand_end) begin
						// full path closes back to vertex 0?
						if (at_full && row[0])
							count_q <= count_q + hcc_pkg::COUNT_W'(1);
						if (depth_q == DW'(1)) begin
							state_q <= S_DONE;
						end else begin
							used_q[top_q] <= 1'b0;
							top_q         <= pop_top;
							depth_q       <= depth_q - DW'(1);
							cand_q        <= DW'(top_q) + DW'(1);
						end
					end else if (push) begin
						used_q[cand_idx] <= 1'b1;
						top_q            <= cand_idx;
						depth_q          <= depth_q + DW'(1);
						cand_q           <= DW'(1);
					end else begin
						cand_q <= cand_q + DW'(1);
					end
				end
				S_DONE: begin
					if (take)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// path stack, no reset; entry 0 is the fixed start vertex
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start)
			stack_q[0] <= '0;
		else if (push)
			stack_q[depth_q[VW-1:0]] <= cand_idx;
	end

endmodule

>>> rtl/hamiltonian_cycle_counter.sv
// Add and clear requests: a new request every cycle while the walker is idle (in_ready high).
// Count request: hcc_search walks the backtracking steps (one test, push or pop per cycle),
//   then the count moves from its done state into the output register once that is free.
// No new request is taken while a count runs; add/clear may go while a result waits.
// Reset (arst_n, async, low): no edges, vertex_count = 16, no result pending.
// The path stack has no reset; it is rebuilt at the start of every count.
`timescale 1ns / 1ps

module hamiltonian_cycle_counter #(
	parameter int MAX_VERTICES = hcc_pkg::MAX_VERTICES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [hcc_pkg::MODE_W-1:0]   mode,
	input  logic [hcc_pkg::VERT_W-1:0]   vertex_a,
	input  logic [hcc_pkg::VERT_W-1:0]   vertex_b,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [hcc_pkg::COUNT_W-1:0]  cycle_count,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [hcc_pkg::VCNT_W-1:0]   vertex_count
);

	localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int DW = $clog2(MAX_VERTICES + 1);

	// adjacency matrix in flops: one row read by the walker, cleared at once
	logic [MAX_VERTICES-1:0]      adj_q [MAX_VERTICES];
	logic [hcc_pkg::VCNT_W-1:0]   vcnt_q;
	logic                         out_valid_q;
	logic [hcc_pkg::COUNT_W-1:0]  out_q;

	logic                         in_fire;
	logic                         edge_ok;
	logic [VW-1:0]                a_idx;
	logic [VW-1:0]                b_idx;
	logic [DW-1:0]                n_vert;
	logic [VW-1:0]                row_addr;
	logic                         take;
	logic                         start;
	hcc_pkg::hcc_stat_t           stat;
	logic [hcc_pkg::COUNT_W-1:0]  count;

	assign in_ready  = !stat.busy;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// endpoints beyond the built size drop the edge
	assign edge_ok = (32'(vertex_a) < MAX_VERTICES) && (32'(vertex_b) < MAX_VERTICES);
	assign a_idx   = VW'(vertex_a);
	assign b_idx   = VW'(vertex_b);

	// vertex count: zero acts as one, large values clamp to the built size
	always_comb begin
		priority if (vcnt_q == '0)
			n_vert = DW'(1);
		else if (32'(vcnt_q) > MAX_VERTICES)
			n_vert = DW'(MAX_VERTICES);
		else
			n_vert = DW'(vcnt_q);
	end

	assign start = in_fire && (mode == hcc_pkg::MODE_COUNT);
	// output register free, or emptied this cycle
	assign take  = !out_valid_q || out_ready;

	hcc_search #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.n_vert   (n_vert),
		.row_addr (row_addr),
		.row      (adj_q[row_addr]),
		.take     (take),
		.stat     (stat),
		.count    (count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_VERTICES; i++)
				adj_q[i] <= '0;
		end else if (in_fire) begin
			if (mode == hcc_pkg::MODE_CLEAR) begin
				for (int i = 0; i < MAX_VERTICES; i++)
					adj_q[i] <= '0;
			end else if (mode == hcc_pkg::MODE_ADD && edge_ok) begin
				// undirected: set both directions
				adj_q[a_idx][b_idx] <= 1'b1;
				adj_q[b_idx][a_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vcnt_q <= hcc_pkg::VCNT_RESET;
		else if (cfg_valid && cfg_ready)
			vcnt_q <= vertex_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.done && take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done && take)
			out_q <= count;
	end

	assign out_valid   = out_valid_q;
	assign cycle_count = out_q;

`ifndef SYNTH
	// a result only appears after the walker finished
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(stat.done))
		else $error("result without finished search");

	// a count request starts the walker
	a_count_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode == hcc_pkg::MODE_COUNT |=> stat.busy)
		else $error("count request did not start search");

	// finished walker holds while the output stage is blocked
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done && out_valid && !out_ready |=> stat.done && out_valid)
		else $error("result lost under output stall");
`endif

endmodule
